@@ hdl/sds_pkg.sv @@
// shared types and constants for the sampled derivative stream
`default_nettype none

package sds_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SLOPE_BITS      = 35;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DIFF_MODE = 1'b0;
    localparam logic REG_RECIP_DX  = 1'b1;

    typedef enum logic [1:0] {
        MODE_FWD = 2'd0,
        MODE_BWD = 2'd1,
        MODE_CEN = 2'd2,
        MODE_SG  = 2'd3
    } diff_mode_t;

    typedef enum logic [1:0] {
        DIV_1  = 2'd0,
        DIV_2  = 2'd1,
        DIV_10 = 2'd2
    } div_sel_t;

    localparam diff_mode_t  DIFF_MODE_RESET = MODE_CEN;
    localparam logic [15:0] RECIP_DX_RESET  = 16'd256;

    typedef struct packed {
        logic     neg;
        div_sel_t div;
        logic     done;
    } job_ctl_t;

endpackage

`default_nettype wire

@@ hdl/sds_window.sv @@
// sample history, run position and queue of difference jobs
`default_nettype none

module sds_window #(
    parameter int SAMPLE_BITS = sds_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sds_pkg::diff_mode_t           diff_mode,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          end_of_run,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    output logic                               job_valid,
    input  wire logic                          job_ready,
    output logic [SAMPLE_BITS+1:0]             job_mag,
    output sds_pkg::job_ctl_t                  job_ctl
);

    localparam int NUM_W = SAMPLE_BITS + 3;
    localparam int MAG_W = SAMPLE_BITS + 2;
    localparam int SLOTS = 4;
    localparam int CNT_W = 3;

    // distance to the end of the run; far means not yet known
    localparam logic [1:0] REL_END = 2'd0;
    localparam logic [1:0] REL_ONE = 2'd1;
    localparam logic [1:0] REL_TWO = 2'd2;
    localparam logic [1:0] REL_FAR = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        sds_pkg::job_ctl_t ctl;
    } job_t;

    function automatic job_t make_job(
        input logic signed [SAMPLE_BITS-1:0] prev,
        input logic signed [SAMPLE_BITS-1:0] cur,
        input logic signed [SAMPLE_BITS-1:0] nxt,
        input logic signed [NUM_W-1:0]       sg_num,
        input logic                          i_zero,
        input logic                          i_low,
        input logic [1:0]                    rel,
        input sds_pkg::diff_mode_t           mode,
        input logic                          done
    );
        logic signed [NUM_W-1:0] d_fwd;
        logic signed [NUM_W-1:0] d_bwd;
        logic signed [NUM_W-1:0] d_cen;
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        abs_num;
        sds_pkg::div_sel_t       div;
        job_t                    j;
        d_fwd = NUM_W'(nxt) - NUM_W'(cur);
        d_bwd = NUM_W'(cur) - NUM_W'(prev);
        d_cen = NUM_W'(nxt) - NUM_W'(prev);
        div   = sds_pkg::DIV_1;
        case (mode)
            sds_pkg::MODE_FWD: num = (rel != REL_END) ? d_fwd : d_bwd;
            sds_pkg::MODE_BWD: num = i_zero ? d_fwd : d_bwd;
            sds_pkg::MODE_CEN:
            begin
                if (i_zero)
                begin
                    num = d_fwd;
                end
                else if (rel == REL_END)
                begin
                    num = d_bwd;
                end
                else
                begin
                    num = d_cen;
                    div = sds_pkg::DIV_2;
                end
            end
            default:
            begin
                if (i_low)
                begin
                    num = (rel != REL_END) ? d_fwd : '0;
                end
                else if (rel == REL_TWO || rel == REL_FAR)
                begin
                    num = sg_num;
                    div = sds_pkg::DIV_10;
                end
                else
                begin
                    num = d_bwd;
                end
            end
        endcase
        abs_num    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        j.mag      = abs_num[MAG_W-1:0];
        j.ctl.neg  = num[NUM_W-1];
        j.ctl.div  = div;
        j.ctl.done = done;
        return j;
    endfunction

    logic signed [SAMPLE_BITS-1:0] hist_reg [4];
    logic [2:0]                    position_reg;
    logic [2:0]                    position_next;
    job_t                          slot_reg [SLOTS];
    job_t                          slot_next [SLOTS];
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;

    logic                          accept;
    logic                          issue;
    logic [CNT_W-1:0]              base;
    logic [CNT_W-1:0]              n_new;
    logic [CNT_W-1:0]              off;
    logic signed [NUM_W-1:0]       sg_num;
    job_t                          job_a;
    job_t                          job_b;
    job_t                          job_c;
    job_t                          new_job [3];

    assign sample_ready = (cnt_reg <= CNT_W'(1));
    assign accept       = sample_valid && sample_ready;
    assign issue        = (cnt_reg != '0) && job_ready;
    assign job_valid    = (cnt_reg != '0);
    assign job_mag      = slot_reg[0].mag;
    assign job_ctl      = slot_reg[0].ctl;

    // window: hist_reg[3] oldest .. sample newest
    assign sg_num = ((NUM_W'(sample) - NUM_W'(hist_reg[3])) <<< 1)
                  + (NUM_W'(hist_reg[0]) - NUM_W'(hist_reg[2]));

    always_comb
    begin
        job_a = make_job(hist_reg[2], hist_reg[1], hist_reg[0], sg_num,
                         position_reg == 3'd2, position_reg < 3'd4,
                         end_of_run ? REL_TWO : REL_FAR, diff_mode, 1'b0);
        job_b = make_job(hist_reg[1], hist_reg[0], sample, sg_num,
                         position_reg == 3'd1, position_reg < 3'd3,
                         REL_ONE, diff_mode, 1'b0);
        job_c = make_job(hist_reg[0], sample, sample, sg_num,
                         position_reg == 3'd0, position_reg < 3'd2,
                         REL_END, diff_mode, 1'b1);

        new_job[0] = job_a;
        new_job[1] = job_b;
        new_job[2] = job_c;
        n_new      = '0;
        if (accept)
        begin
            if (end_of_run)
            begin
                if (position_reg >= 3'd2)
                begin
                    n_new = CNT_W'(3);
                end
                else if (position_reg == 3'd1)
                begin
                    // short run: only the last two indices exist
                    new_job[0] = job_b;
                    new_job[1] = job_c;
                    n_new      = CNT_W'(2);
                end
            end
            else if (position_reg >= 3'd2)
            begin
                n_new = CNT_W'(1);
            end
        end

        base = cnt_reg - CNT_W'(issue);
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_next[s] = (s < SLOTS - 1 && issue) ? slot_reg[(s + 1) % SLOTS] : slot_reg[s];
            off          = CNT_W'(s) - base;
            if (CNT_W'(s) >= base && CNT_W'(s) < base + n_new)
            begin
                slot_next[s] = new_job[off[1:0]];
            end
        end
        cnt_next = base + n_new;

        position_next = position_reg;
        if (accept)
        begin
            if (end_of_run)
            begin
                position_next = '0;
            end
            else if (position_reg != 3'd7)
            begin
                position_next = position_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            position_reg <= '0;
            for (int h = 0; h < 4; h++)
            begin
                hist_reg[h] <= '0;
            end
        end
        else
        begin
            cnt_reg      <= cnt_next;
            position_reg <= position_next;
            if (accept)
            begin
                hist_reg[0] <= sample;
                hist_reg[1] <= hist_reg[0];
                hist_reg[2] <= hist_reg[1];
                hist_reg[3] <= hist_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_reg[s] <= slot_next[s];
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("job queue overfilled");

    a_flush_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_run && position_reg != 3'd0) |=> cnt_reg >= CNT_W'(2))
        else $error("end of run did not queue its flush");

endmodule

`default_nettype wire

@@ hdl/sds_scale.sv @@
// scaling pipeline: magnitude times recip_dx, divided by 1, 2 or 10, saturated
`default_nettype none

module sds_scale #(
    parameter int SAMPLE_BITS = sds_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [15:0]                           recip_dx,
    input  wire logic                                  job_valid,
    output logic                                       job_ready,
    input  wire logic [SAMPLE_BITS+1:0]                job_mag,
    input  wire sds_pkg::job_ctl_t                     job_ctl,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output logic signed [sds_pkg::SLOPE_BITS-1:0]      res_slope,
    output logic [sds_pkg::SLOPE_BITS-1:0]             res_mag,
    output logic                                       res_done
);

    localparam int MAG_W = SAMPLE_BITS + 2;
    // exact m/10 by reciprocal for m < 2**MAG_W
    localparam int SH1  = MAG_W + 4;
    localparam int K1_W = MAG_W + 1;
    localparam int P1_W = MAG_W + K1_W;
    localparam logic [K1_W-1:0] K1 = K1_W'(((64'd1 << SH1) + 64'd9) / 64'd10);
    localparam int PA_W = MAG_W + 16;
    // remainder product is below 10 * 2**16
    localparam int PB_W = 20;
    localparam int SH2  = PB_W + 4;
    localparam int K2_W = PB_W + 1;
    localparam int P2_W = PB_W + K2_W;
    localparam logic [K2_W-1:0] K2 = K2_W'(((64'd1 << SH2) + 64'd9) / 64'd10);
    localparam int SB   = sds_pkg::SLOPE_BITS;
    localparam int EXT_W = (PA_W + 1 > SB) ? PA_W + 1 : SB;
    localparam logic [EXT_W-1:0] POS_MAX = EXT_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [EXT_W-1:0] NEG_MAX = EXT_W'(64'd1 << (SB - 1));

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                  rdy1, rdy2, rdy3, rdy4, rdy5;
    sds_pkg::job_ctl_t     ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic                  done5_reg;

    logic [MAG_W-1:0]      m1_reg;
    logic [P1_W-1:0]       p1_reg;
    logic [P1_W-1:0]       p1_next;
    logic [MAG_W-1:0]      q2_reg;
    logic [MAG_W-1:0]      q2_next;
    logic [3:0]            rem2_reg;
    logic [3:0]            rem2_next;
    logic [PA_W-1:0]       pa3_reg;
    logic [PA_W-1:0]       pa3_next;
    logic [PB_W-1:0]       pb3_reg;
    logic [PB_W-1:0]       pb3_next;
    logic [PA_W-1:0]       pa4_reg;
    logic [15:0]           pb4_reg;
    logic [15:0]           pb4_next;
    logic signed [SB-1:0]  slope5_reg;
    logic signed [SB-1:0]  slope5_next;
    logic [SB-1:0]         mag5_reg;
    logic [SB-1:0]         mag5_next;

    logic [MAG_W-1:0]      q_div;
    logic [MAG_W-1:0]      q_x10;
    logic [MAG_W-1:0]      rem_full;
    logic [15:0]           r_eff;
    logic [P2_W-1:0]       prod2;
    logic [PA_W-1:0]       mag_sum;
    logic [EXT_W-1:0]      mag_ext;
    logic [EXT_W-1:0]      mag_sat;

    // a stage takes a beat when it is empty or its beat moves on
    assign rdy5      = !v5_reg || res_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign job_ready = rdy1;

    assign r_eff = (recip_dx == '0) ? 16'd256 : recip_dx;

    always_comb
    begin
        p1_next = P1_W'(job_mag) * P1_W'(K1);

        q_div    = MAG_W'(p1_reg >> SH1);
        q_x10    = (q_div << 3) + (q_div << 1);
        rem_full = m1_reg - q_x10;
        if (ctl1_reg.div == sds_pkg::DIV_10)
        begin
            q2_next   = q_div;
            rem2_next = rem_full[3:0];
        end
        else
        begin
            q2_next   = m1_reg;
            rem2_next = '0;
        end

        pa3_next = PA_W'(q2_reg) * PA_W'(r_eff);
        pb3_next = PB_W'(rem2_reg) * PB_W'(r_eff);

        prod2    = P2_W'(pb3_reg) * P2_W'(K2);
        pb4_next = 16'(prod2 >> SH2);

        case (ctl4_reg.div)
            sds_pkg::DIV_2:  mag_sum = pa4_reg >> 1;
            sds_pkg::DIV_10: mag_sum = pa4_reg + PA_W'(pb4_reg);
            default:         mag_sum = pa4_reg;
        endcase
        mag_ext = EXT_W'(mag_sum);
        mag_sat = mag_ext;
        if (!ctl4_reg.neg && mag_ext > POS_MAX)
        begin
            mag_sat = POS_MAX;
        end
        else if (ctl4_reg.neg && mag_ext > NEG_MAX)
        begin
            mag_sat = NEG_MAX;
        end
        mag5_next   = mag_sat[SB-1:0];
        slope5_next = ctl4_reg.neg ? SB'(-mag5_next) : SB'(mag5_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= job_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && job_valid)
        begin
            ctl1_reg <= job_ctl;
            m1_reg   <= job_mag;
            p1_reg   <= p1_next;
        end
        if (rdy2 && v1_reg)
        begin
            ctl2_reg <= ctl1_reg;
            q2_reg   <= q2_next;
            rem2_reg <= rem2_next;
        end
        if (rdy3 && v2_reg)
        begin
            ctl3_reg <= ctl2_reg;
            pa3_reg  <= pa3_next;
            pb3_reg  <= pb3_next;
        end
        if (rdy4 && v3_reg)
        begin
            ctl4_reg <= ctl3_reg;
            pa4_reg  <= pa3_reg;
            pb4_reg  <= pb4_next;
        end
        if (rdy5 && v4_reg)
        begin
            done5_reg  <= ctl4_reg.done;
            slope5_reg <= slope5_next;
            mag5_reg   <= mag5_next;
        end
    end

    assign res_valid = v5_reg;
    assign res_slope = slope5_reg;
    assign res_mag   = mag5_reg;
    assign res_done  = done5_reg;

endmodule

`default_nettype wire

@@ hdl/sds_peak.sv @@
// output register with running peak of the slope magnitude
`default_nettype none

module sds_peak (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  res_valid,
    output logic                                       res_ready,
    input  wire logic signed [sds_pkg::SLOPE_BITS-1:0] res_slope,
    input  wire logic [sds_pkg::SLOPE_BITS-1:0]        res_mag,
    input  wire logic                                  res_done,
    output logic                                       slope_valid,
    input  wire logic                                  slope_ready,
    output logic signed [sds_pkg::SLOPE_BITS-1:0]      slope,
    output logic                                       run_done,
    output logic [sds_pkg::SLOPE_BITS-1:0]             peak_slope
);

    localparam int SB = sds_pkg::SLOPE_BITS;

    logic                 valid_reg;
    logic signed [SB-1:0] slope_reg;
    logic                 done_reg;
    logic [SB-1:0]        peak_reg;
    logic [SB-1:0]        peak_next;
    logic                 load;

    assign res_ready = !valid_reg || slope_ready;
    assign load      = res_valid && res_ready;
    assign peak_next = (res_mag > peak_reg) ? res_mag : peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            peak_reg  <= '0;
        end
        else
        begin
            if (res_ready)
            begin
                valid_reg <= res_valid;
            end
            if (load)
            begin
                peak_reg <= peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slope_reg <= res_slope;
            done_reg  <= res_done;
        end
    end

    assign slope_valid = valid_reg;
    assign slope       = slope_reg;
    assign run_done    = done_reg;
    assign peak_slope  = peak_reg;

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak decreased");

    a_peak_covers_slope: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> peak_reg >= (slope_reg[SB-1] ? SB'(-slope_reg) : SB'(slope_reg)))
        else $error("peak below held slope");

endmodule

`default_nettype wire

@@ hdl/sampled_derivative_stream.sv @@
// top level: register port, window, scaling pipeline and output stage
//
// Streaming first derivative of runs of signed samples.
// Input channel: sample and end_of_run move on a sample_valid/sample_ready beat;
// end_of_run marks the last sample of a run. Output channel: slope, run_done
// and peak_slope move on a slope_valid/slope_ready beat, one beat per sample
// of the run (a run of one sample gives none).
// Configuration: APB write of diff_mode (address 0) and recip_dx (address 4),
// only while the block is idle. pready is always high.
// The slope of sample i enters the job queue on the beat that completes its
// window (sample i+2, or the end of the run), then passes the scaling pipeline
// and the output register. Throughput: one sample per cycle inside a run while
// the pipeline takes jobs; the end-of-run beat queues up to three slopes in the
// four-entry job queue; the next sample then waits until at most one is left.
// Reset clears the run position, history, queue, pipeline and the peak, and
// loads diff_mode central and recip_dx 256.
// When the receiver stalls, the output register holds its beat, the pipeline
// fills behind it, and sample_ready drops once the job queue has two entries.
`default_nettype none

module sampled_derivative_stream #(
    parameter int SAMPLE_BITS = sds_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [sds_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [sds_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [sds_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample,
    input  wire logic                                  end_of_run,
    input  wire logic                                  sample_valid,
    output logic                                       sample_ready,
    output logic signed [sds_pkg::SLOPE_BITS-1:0]      slope,
    output logic                                       run_done,
    output logic [sds_pkg::SLOPE_BITS-1:0]             peak_slope,
    output logic                                       slope_valid,
    input  wire logic                                  slope_ready
);

    sds_pkg::diff_mode_t        diff_mode_reg;
    logic [15:0]                recip_dx_reg;
    logic                       wr_en;
    logic                       reg_sel;

    logic                       job_valid;
    logic                       job_ready;
    logic [SAMPLE_BITS+1:0]     job_mag;
    sds_pkg::job_ctl_t          job_ctl;

    logic                                  res_valid;
    logic                                  res_ready;
    logic signed [sds_pkg::SLOPE_BITS-1:0] res_slope;
    logic [sds_pkg::SLOPE_BITS-1:0]        res_mag;
    logic                                  res_done;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_mode_reg <= sds_pkg::DIFF_MODE_RESET;
            recip_dx_reg  <= sds_pkg::RECIP_DX_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sds_pkg::REG_DIFF_MODE:
                    diff_mode_reg <= sds_pkg::diff_mode_t'(pwdata[1:0]);
                sds_pkg::REG_RECIP_DX:  recip_dx_reg  <= pwdata[15:0];
                default:                recip_dx_reg  <= recip_dx_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sds_pkg::REG_DIFF_MODE: prdata = {30'd0, diff_mode_reg};
            sds_pkg::REG_RECIP_DX:  prdata = {16'd0, recip_dx_reg};
            default:                prdata = '0;
        endcase
    end

    sds_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .diff_mode    (diff_mode_reg),
        .sample       (sample),
        .end_of_run   (end_of_run),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job_mag      (job_mag),
        .job_ctl      (job_ctl)
    );

    sds_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .recip_dx  (recip_dx_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_mag   (job_mag),
        .job_ctl   (job_ctl),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_slope (res_slope),
        .res_mag   (res_mag),
        .res_done  (res_done)
    );

    sds_peak u_peak (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_slope   (res_slope),
        .res_mag     (res_mag),
        .res_done    (res_done),
        .slope_valid (slope_valid),
        .slope_ready (slope_ready),
        .slope       (slope),
        .run_done    (run_done),
        .peak_slope  (peak_slope)
    );

endmodule

`default_nettype wire

@@ dv/sampled_derivative_stream_tb.sv @@
// self-checking testbench for the sampled derivative stream block
`default_nettype none

module sampled_derivative_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W        = sds_pkg::SAMPLE_BITS_DEF;
    localparam int SLP_W        = sds_pkg::SLOPE_BITS;
    localparam int ADDR_W       = sds_pkg::APB_ADDR_W;
    localparam int DATA_W       = sds_pkg::APB_DATA_W;
    localparam int FAR_FROM_END = 3;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_STALL   = 200;
    localparam int QUIET_LIMIT  = 1500;
    localparam int PHASE_ITEMS  = 26;

    localparam logic [ADDR_W-1:0] ADDR_DIFF_MODE = {sds_pkg::REG_DIFF_MODE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RECIP_DX  = {sds_pkg::REG_RECIP_DX, 2'b00};

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    eor;
    } sample_beat_t;

    typedef struct packed {
        logic signed [SLP_W-1:0] slope;
        logic                    done;
        logic [SLP_W-1:0]        peak;
    } slope_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [ADDR_W-1:0]            paddr   = '0;
    logic [DATA_W-1:0]            pwdata  = '0;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;
    logic signed [SMP_W-1:0]      sample       = '0;
    logic                         end_of_run   = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_ready;
    logic signed [SLP_W-1:0]      slope;
    logic                         run_done;
    logic [SLP_W-1:0]             peak_slope;
    logic                         slope_valid;
    logic                         slope_ready  = 1'b0;

    sampled_derivative_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample       (sample),
        .end_of_run   (end_of_run),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .slope        (slope),
        .run_done     (run_done),
        .peak_slope   (peak_slope),
        .slope_valid  (slope_valid),
        .slope_ready  (slope_ready)
    );

    always #6 clk = ~clk;

    sample_beat_t sample_queue[$];
    slope_beat_t  pending_slopes[$];
    sample_beat_t on_bus;

    // predictor copy of registers and state
    sds_pkg::diff_mode_t     mode_cfg = sds_pkg::DIFF_MODE_RESET;
    logic [15:0]             rdx_cfg  = sds_pkg::RECIP_DX_RESET;
    logic signed [SMP_W-1:0] hist[4]  = '{default: '0};
    logic [2:0]              run_pos  = '0;
    longint                  peak_mag = 0;
    longint                  win[5];

    int src_idle_pct    = 0;
    int rcv_stall_pct   = 0;
    int long_stall_asks = 0;
    int long_stall_done = 0;
    int stall_left      = 0;
    int accepted_items  = 0;
    int runs_seen       = 0;
    int slopes_checked  = 0;
    int errors          = 0;
    int quiet_cycles    = 0;

    function automatic longint calc_slope(input int j, input int idx, input int rel);
        longint num;
        longint r;
        longint v;
        longint lim;
        longint dv;
        num = 0;
        dv  = 1;
        r   = longint'(rdx_cfg);
        lim = longint'(1) <<< (SLP_W - 1);
        if (r == 0)
            r = 256;
        case (mode_cfg)
            sds_pkg::MODE_FWD: num = (rel >= 1) ? win[j+1] - win[j] : win[j] - win[j-1];
            sds_pkg::MODE_BWD: num = (idx >= 1) ? win[j] - win[j-1] : win[j+1] - win[j];
            sds_pkg::MODE_CEN:
            begin
                if (idx == 0)
                    num = win[j+1] - win[j];
                else if (rel == 0)
                    num = win[j] - win[j-1];
                else
                begin
                    num = win[j+1] - win[j-1];
                    dv  = 2;
                end
            end
            default:
            begin
                if (idx < 2)
                    num = (rel >= 1) ? win[j+1] - win[j] : 0;
                else if (rel >= 2 && j == 2)
                begin
                    num = 2 * (win[4] - win[0]) + (win[3] - win[1]);
                    dv  = 10;
                end
                else
                    num = win[j] - win[j-1];
            end
        endcase
        v = (num * r) / dv;
        if (v > lim - 1)
            v = lim - 1;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    task automatic push_slope(input longint v, input logic done);
        slope_beat_t b;
        longint mag;
        mag = (v < 0) ? -v : v;
        if (mag > peak_mag)
            peak_mag = mag;
        b.slope = v[SLP_W-1:0];
        b.done  = done;
        b.peak  = peak_mag[SLP_W-1:0];
        pending_slopes.push_back(b);
    endtask

    // one sample beat: slide the window and queue the slopes it completes
    task automatic advance_window(input sample_beat_t b);
        int k;
        int rel;
        k = run_pos;
        win[4] = b.smp;
        win[3] = hist[0];
        win[2] = hist[1];
        win[1] = hist[2];
        win[0] = hist[3];
        if (!b.eor)
        begin
            if (k >= 2)
                push_slope(calc_slope(2, k - 2, FAR_FROM_END), 1'b0);
            if (run_pos < 3'd7)
                run_pos = run_pos + 3'd1;
        end
        else
        begin
            // end of run flushes up to three slopes, oldest first
            for (rel = 2; rel >= 0; rel--)
            begin
                if (k >= 1 && k >= rel)
                    push_slope(calc_slope(4 - rel, k - rel, rel), rel == 0);
            end
            run_pos = '0;
        end
        hist[3] = hist[2];
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = b.smp;
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && sample_ready)
            begin
                advance_window(on_bus);
                accepted_items++;
                if (on_bus.eor)
                    runs_seen++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    on_bus = sample_queue.pop_front();
                    sample       <= on_bus.smp;
                    end_of_run   <= on_bus.eor;
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // slope monitor and receiver stalls
    always @(posedge clk)
    begin
        slope_beat_t exp_beat;
        if (!rst_n)
            slope_ready <= 1'b0;
        else
        begin
            if (slope_valid && slope_ready)
            begin
                if (pending_slopes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected slope beat %0d", $time, slope);
                end
                else
                begin
                    exp_beat = pending_slopes.pop_front();
                    slopes_checked++;
                    if (slope !== exp_beat.slope)
                    begin
                        errors++;
                        $display("%0t: slope expected %0d got %0d",
                                 $time, exp_beat.slope, slope);
                    end
                    if (run_done !== exp_beat.done)
                    begin
                        errors++;
                        $display("%0t: run_done expected %0d got %0d",
                                 $time, exp_beat.done, run_done);
                    end
                    if (peak_slope !== exp_beat.peak)
                    begin
                        errors++;
                        $display("%0t: peak_slope expected %0d got %0d",
                                 $time, exp_beat.peak, peak_slope);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                slope_ready <= 1'b0;
            end
            else if (long_stall_done != long_stall_asks)
            begin
                long_stall_done++;
                stall_left = LONG_STALL;
                slope_ready <= 1'b0;
            end
            else
                slope_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (slope_valid && slope_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input sds_pkg::diff_mode_t m, input logic [15:0] r);
        reg_write(ADDR_DIFF_MODE, DATA_W'(m));
        reg_write(ADDR_RECIP_DX, DATA_W'(r));
        mode_cfg = m;
        rdx_cfg  = r;
    endtask

    // wait at a falling edge until the input side is empty and every slope is in
    task automatic drain(input int extra);
        @(negedge clk);
        while (sample_queue.size() != 0 || sample_valid || pending_slopes.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic add_item(input logic signed [SMP_W-1:0] smp, input logic eor);
        sample_beat_t b;
        b.smp = smp;
        b.eor = eor;
        sample_queue.push_back(b);
    endtask

    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return {1'b1, {(SMP_W-1){1'b0}}};
            1: return {1'b0, {(SMP_W-1){1'b1}}};
            2: return SMP_W'($signed($urandom_range(0, 31)) - 16);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic queue_run(input int len);
        int i;
        for (i = 0; i < len; i++)
            add_item(rand_sample(), i == len - 1);
    endtask

    initial
    begin
        int ph;
        int added;
        int len;
        logic [15:0] rdx;
        bit paused;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, lone sample, extremes, shortest runs
        @(negedge clk);
        add_item(16'sh8000, 1'b1);
        add_item(16'sh7fff, 1'b0);
        add_item(16'sh8000, 1'b0);
        add_item(16'sh7fff, 1'b1);
        add_item(16'sh0000, 1'b0);
        add_item(-16'sd1, 1'b1);
        drain(DRAIN_CYCLES);
        set_regs(sds_pkg::MODE_FWD, 16'hffff);
        @(negedge clk);
        add_item(16'sh8000, 1'b0);
        add_item(16'sh7fff, 1'b0);
        add_item(16'sh8000, 1'b1);
        drain(DRAIN_CYCLES);
        set_regs(sds_pkg::MODE_BWD, 16'd1);
        @(negedge clk);
        add_item(16'sd5, 1'b0);
        add_item(-16'sd7, 1'b0);
        add_item(16'sh7fff, 1'b1);
        drain(DRAIN_CYCLES);
        // zero recip_dx register behaves as recip_dx 256
        set_regs(sds_pkg::MODE_SG, 16'd0);
        @(negedge clk);
        add_item(16'sh7fff, 1'b0);
        add_item(16'sh8000, 1'b1);
        add_item(16'sh7fff, 1'b0);
        add_item(16'sh8000, 1'b0);
        add_item(16'sh0000, 1'b0);
        add_item(16'sh7fff, 1'b0);
        add_item(16'sh8000, 1'b1);
        add_item(16'sh0000, 1'b1);

        for (ph = 0; ph < 8; ph++)
        begin
            drain(DRAIN_CYCLES);
            case (ph)
                0, 6:    rdx = 16'hffff;
                1:       rdx = 16'd1;
                3:       rdx = 16'd256;
                4:       rdx = 16'd0;
                default: rdx = 16'($urandom_range(1, 65535));
            endcase
            set_regs(sds_pkg::diff_mode_t'(ph % 4), rdx);
            @(negedge clk);
            case (ph / 2)
                0:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 65;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    rcv_stall_pct = 65;
                end
                default:
                begin
                    src_idle_pct  = 6;
                    rcv_stall_pct = 6;
                end
            endcase
            // receiver holds off while the sender keeps offering
            if (ph == 1)
                long_stall_asks = long_stall_asks + 1;
            added  = 0;
            paused = 1'b0;
            while (added < PHASE_ITEMS)
            begin
                len = ($urandom_range(19) < 15) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 20);
                queue_run(len);
                added += len;
                if (ph % 2 == 1 && !paused && added >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    drain(0);
                end
            end
        end
        drain(DRAIN_CYCLES);

        $display("run covered %0d samples in %0d runs over all four modes,",
                 accepted_items, runs_seen);
        $display("%0d slopes checked with spacing extremes and stall phases, %0d errors",
                 slopes_checked, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
